/* rtl/cu_pkg.sv */
// shared types and constants for the cross usefulness block
`default_nettype none
package cu_pkg;
    typedef enum logic [1:0] {
        REQ_EFFECT  = 2'd0,
        REQ_ALLELE  = 2'd1,
        REQ_CODES   = 2'd2,
        REQ_EVAL    = 2'd3
    } req_t;

    localparam logic [1:0] CFG_PARENTS = 2'd0;
    localparam logic [1:0] CFG_PROGENY = 2'd1;
    localparam logic [1:0] CFG_LOCI    = 2'd2;
    localparam logic [1:0] CFG_BEST    = 2'd3;

    localparam int STORE_PROGENY = 64;
    localparam int CODE_WORDS    = 4;
    localparam int SUM_W         = 48;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_CLEAR,
        ST_ADDR,
        ST_READ,
        ST_ACC,
        ST_SORT,
        ST_TOTAL,
        ST_DIV,
        ST_OUT
    } state_t;

    // control from sequencer to the accumulating cells
    typedef struct packed {
        logic clear;
        logic acc;
        logic sort_even;
        logic sort_odd;
        logic shift;
    } cell_ctl_t;
endpackage
`default_nettype wire

/* rtl/cu_cell.sv */
// one progeny cell: accumulates its sum, compare-swaps, shifts toward cell zero
`default_nettype none
module cu_cell (
    input  wire logic                      clk,
    input  wire cu_pkg::cell_ctl_t         ctl,
    input  wire logic                      active,
    input  wire logic [1:0]                code_a,
    input  wire logic [1:0]                code_b,
    input  wire logic signed [cu_pkg::SUM_W-1:0] x0,
    input  wire logic signed [cu_pkg::SUM_W-1:0] x1,
    input  wire logic signed [cu_pkg::SUM_W-1:0] x2,
    input  wire logic signed [cu_pkg::SUM_W-1:0] x3,
    input  wire logic signed [cu_pkg::SUM_W-1:0] left_val,
    input  wire logic signed [cu_pkg::SUM_W-1:0] right_val,
    input  wire logic                      is_low,
    input  wire logic                      pair_en,
    input  wire logic                      right_in_range,
    output logic signed [cu_pkg::SUM_W-1:0] val
);
    logic signed [cu_pkg::SUM_W-1:0] val_reg, val_next, pa, pb;

    // allele effect picked by each haplotype code
    always_comb
    begin
        unique case (code_a)
            2'd0: pa = x0;
            2'd1: pa = x1;
            2'd2: pa = x2;
            default: pa = x3;
        endcase
        unique case (code_b)
            2'd0: pb = x0;
            2'd1: pb = x1;
            2'd2: pb = x2;
            default: pb = x3;
        endcase
    end

    // accumulate, sort network step, or shift
    always_comb
    begin
        val_next = val_reg;
        if (ctl.clear)
            val_next = '0;
        else if (ctl.acc && active)
            val_next = val_reg + pa + pb;
        else if ((ctl.sort_even || ctl.sort_odd) && pair_en)
        begin
            if (is_low && right_in_range && right_val > val_reg)
                val_next = right_val;
            else if (!is_low && left_val < val_reg)
                val_next = left_val;
        end
        else if (ctl.shift)
            val_next = right_val;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
endmodule
`default_nettype wire

/* rtl/cu_div.sv */
// restoring divider of a signed total by a small count, one bit a cycle
`default_nettype none
module cu_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic signed [cu_pkg::SUM_W-1:0] dividend,
    input  wire logic [8:0]                     divisor,
    output logic                                done,
    output logic signed [cu_pkg::SUM_W-1:0]     quotient
);
    localparam int W = cu_pkg::SUM_W;
    logic [W-1:0] q_reg, q_next, mag;
    logic [9:0]   rem_reg, rem_next, trial;
    logic [5:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next, neg_reg, neg_next;

    assign mag = dividend[W-1] ? W'(-dividend) : W'(dividend);
    assign trial = {rem_reg[8:0], q_reg[W-1]};

    // shift-subtract step
    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        if (start)
        begin
            q_next = mag;
            rem_next = '0;
            cnt_next = 6'(W);
            busy_next = 1'b1;
            neg_next = dividend[W-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done = busy_reg && (cnt_reg == 6'd1);
    assign quotient = neg_reg ? W'(-q_next) : W'(q_next);
endmodule
`default_nettype wire

/* rtl/cross_usefulness_top_mean.sv */
// top level: stores, sequencer, cell row and divider for cross usefulness
//
// channel  dir  handshake                 payload
// s_axis   in   s_axis_tvalid/tready      tdata, tuser = req_type
// m_axis   out  m_axis_tvalid/tready      tdata
// cfg      in   cfg_we                    cfg_index, cfg_data
//
// loads are written when taken; an evaluation steps through each locus (four code word reads,
// a read cycle, an accumulate), then makes one compare-swap pass a cycle in the cell row,
// takes one averaged value a cycle, and one bit a cycle over 48 bits in the divider.
// the result waits in an output register; a new word is taken once it is loaded.
// rst_n clears control state only, stores hold garbage until written.
`default_nettype none
module cross_usefulness_top_mean #(
    parameter int MAX_PARENTS = 32,
    parameter int MAX_PROGENY = 64,
    parameter int MAX_LOCI    = 1024,
    parameter int EFFECT_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // locus[9:0], chunk[11:10], data_word[75:12], effect[91:76], pair_index[100:92]
    input  wire logic [103:0] s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // usefulness[31:0], first_parent[36:32], second_parent[41:37], bad_pair[42]
    output logic [47:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);
    localparam int SW = cu_pkg::SUM_W;
    localparam int NP = cu_pkg::STORE_PROGENY;
    localparam int LA = (MAX_LOCI > 1) ? $clog2(MAX_LOCI) : 1;
    localparam int PROG_CAP = (MAX_PROGENY < NP) ? MAX_PROGENY : NP;

    // payload fields
    logic [9:0]  in_locus;
    logic [1:0]  in_chunk;
    logic [63:0] in_word;
    logic [15:0] in_effect;
    logic [8:0]  in_pair;
    assign in_locus  = s_axis_tdata[9:0];
    assign in_chunk  = s_axis_tdata[11:10];
    assign in_word   = s_axis_tdata[75:12];
    assign in_effect = s_axis_tdata[91:76];
    assign in_pair   = s_axis_tdata[100:92];

    // configuration registers
    logic [5:0]  np_cfg_reg;
    logic [6:0]  prog_cfg_reg, best_cfg_reg;
    logic [10:0] loci_cfg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_cfg_reg <= 6'd32;
            prog_cfg_reg <= 7'd64;
            loci_cfg_reg <= 11'd1024;
            best_cfg_reg <= 7'd50;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cu_pkg::CFG_PARENTS: np_cfg_reg <= cfg_data[5:0];
                cu_pkg::CFG_PROGENY: prog_cfg_reg <= cfg_data[6:0];
                cu_pkg::CFG_LOCI:    loci_cfg_reg <= cfg_data;
                default:             best_cfg_reg <= cfg_data[6:0];
            endcase
        end
    end

    // effective counts
    logic [5:0]  np_eff;
    logic [6:0]  prog_eff, best_eff;
    logic [16:0] loci_eff;
    assign np_eff = (np_cfg_reg > 6'(MAX_PARENTS)) ? 6'(MAX_PARENTS) : np_cfg_reg;
    assign prog_eff = (prog_cfg_reg == 7'd0) ? 7'd1 :
                      (prog_cfg_reg > 7'(PROG_CAP)) ? 7'(PROG_CAP) : prog_cfg_reg;
    assign best_eff = (best_cfg_reg == 7'd0) ? 7'd1 :
                      (best_cfg_reg > prog_eff) ? prog_eff : best_cfg_reg;
    assign loci_eff = (17'(loci_cfg_reg) > 17'(MAX_LOCI)) ? 17'(MAX_LOCI)
                                                          : 17'(loci_cfg_reg);

    // stores
    logic [EFFECT_BITS-1:0] eff_mem [MAX_LOCI];
    logic [63:0] all_mem [MAX_LOCI];
    logic [63:0] code_mem [MAX_LOCI*cu_pkg::CODE_WORDS];
    logic [EFFECT_BITS-1:0] eff_rd_reg;
    logic [63:0] all_rd_reg;
    logic [63:0] code_rd_reg [cu_pkg::CODE_WORDS];

    logic take, load_ok;
    logic [LA-1:0] rd_addr_reg, rd_addr_next;
    logic [1:0] rd_chunk_reg, rd_chunk_next;
    assign take = s_axis_tvalid && s_axis_tready;
    assign load_ok = 32'(in_locus) < MAX_LOCI;

    // effect is taken as EFFECT_BITS bits, zero-extended when wider than the field
    always_ff @(posedge clk)
    begin
        if (take && load_ok && s_axis_tuser == cu_pkg::REQ_EFFECT)
            eff_mem[LA'(in_locus)] <= EFFECT_BITS'(in_effect);
        if (take && load_ok && s_axis_tuser == cu_pkg::REQ_ALLELE)
            all_mem[LA'(in_locus)] <= in_word;
        if (take && load_ok && s_axis_tuser == cu_pkg::REQ_CODES)
            code_mem[{LA'(in_locus), in_chunk}] <= in_word;
        eff_rd_reg <= eff_mem[rd_addr_reg];
        all_rd_reg <= all_mem[rd_addr_reg];
        code_rd_reg[rd_chunk_reg] <= code_mem[{rd_addr_reg, rd_chunk_reg}];
    end

    // sequencer
    cu_pkg::state_t st_reg, st_next;
    logic [8:0]  k_reg, k_next;
    logic [4:0]  row_reg, row_next, pi_reg, pi_next, pj_reg, pj_next;
    logic [16:0] lc_reg, lc_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        bad_reg, bad_next, out_v_reg, out_v_next;
    logic signed [SW-1:0] tot_reg, tot_next;
    logic signed [SW-1:0] x_reg [4];
    logic [47:0] out_reg, out_next;
    logic        div_start, div_done;
    logic signed [SW-1:0] quot, clamped;
    logic signed [SW-1:0] quot_w;
    logic signed [SW-1:0] cell_v [NP];
    logic [9:0]  pairs;
    logic [5:0]  rowlen;
    cu_pkg::cell_ctl_t ctl;

    assign pairs = (np_eff >= 6'd2) ? 10'((11'(np_eff) * 11'(np_eff - 6'd1)) >> 1) : 10'd0;
    assign rowlen = np_eff - 6'd1 - 6'(row_reg);
    assign clamped = (quot > SW'(64'sh7FFFFFFF)) ? SW'(64'sh7FFFFFFF) :
                     (quot < -SW'(64'sh80000000)) ? -SW'(64'sh80000000) : quot;

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            cu_pkg::ST_IDLE:
                if (take && s_axis_tuser == cu_pkg::REQ_EVAL)
                    st_next = (10'(in_pair) < pairs) ? cu_pkg::ST_MAP : cu_pkg::ST_OUT;
            cu_pkg::ST_MAP:
                if (10'(k_reg) < 10'(rowlen))
                    st_next = cu_pkg::ST_CLEAR;
            cu_pkg::ST_CLEAR:
                st_next = (lc_reg == 17'd0) ? cu_pkg::ST_SORT : cu_pkg::ST_ADDR;
            cu_pkg::ST_ADDR:
                st_next = (rd_chunk_reg == 2'd3) ? cu_pkg::ST_READ : cu_pkg::ST_ADDR;
            cu_pkg::ST_READ:
                st_next = cu_pkg::ST_ACC;
            cu_pkg::ST_ACC:
                st_next = (lc_reg == 17'd1) ? cu_pkg::ST_SORT : cu_pkg::ST_ADDR;
            cu_pkg::ST_SORT:
                if (cnt_reg == 7'd0)
                    st_next = cu_pkg::ST_TOTAL;
            cu_pkg::ST_TOTAL:
                if (cnt_reg == 7'd0)
                    st_next = cu_pkg::ST_DIV;
            cu_pkg::ST_DIV:
                if (div_done)
                    st_next = cu_pkg::ST_OUT;
            cu_pkg::ST_OUT:
                if (!out_v_reg || m_axis_tready)
                    st_next = cu_pkg::ST_IDLE;
            default:
                st_next = cu_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        k_next = k_reg;
        row_next = row_reg;
        pi_next = pi_reg;
        pj_next = pj_reg;
        lc_next = lc_reg;
        cnt_next = cnt_reg;
        bad_next = bad_reg;
        tot_next = tot_reg;
        rd_addr_next = rd_addr_reg;
        rd_chunk_next = rd_chunk_reg;
        out_v_next = out_v_reg;
        out_next = out_reg;
        ctl = '0;
        div_start = 1'b0;
        if (out_v_reg && m_axis_tready)
            out_v_next = 1'b0;
        unique case (st_reg)
            cu_pkg::ST_IDLE:
                if (take && s_axis_tuser == cu_pkg::REQ_EVAL)
                begin
                    k_next = in_pair;
                    row_next = '0;
                    bad_next = !(10'(in_pair) < pairs);
                end
            cu_pkg::ST_MAP:
                if (10'(k_reg) < 10'(rowlen))
                begin
                    pi_next = row_reg;
                    pj_next = 5'(row_reg + 5'd1 + 5'(k_reg));
                    lc_next = loci_eff;
                    rd_addr_next = '0;
                    rd_chunk_next = '0;
                end
                else
                begin
                    k_next = k_reg - 9'(rowlen);
                    row_next = row_reg + 5'd1;
                end
            cu_pkg::ST_CLEAR:
                ctl.clear = 1'b1;
            cu_pkg::ST_ADDR:
                rd_chunk_next = rd_chunk_reg + 2'd1;
            cu_pkg::ST_READ:
                ;
            cu_pkg::ST_ACC:
            begin
                ctl.acc = 1'b1;
                lc_next = lc_reg - 17'd1;
                rd_addr_next = rd_addr_reg + LA'(1);
                cnt_next = prog_eff;
            end
            cu_pkg::ST_SORT:
            begin
                ctl.sort_even = !cnt_reg[0];
                ctl.sort_odd = cnt_reg[0];
                if (cnt_reg == 7'd0)
                begin
                    cnt_next = best_eff;
                    tot_next = '0;
                end
                else
                    cnt_next = cnt_reg - 7'd1;
            end
            cu_pkg::ST_TOTAL:
                if (cnt_reg == 7'd0)
                    div_start = 1'b1;
                else
                begin
                    ctl.shift = 1'b1;
                    tot_next = tot_reg + cell_v[0];
                    cnt_next = cnt_reg - 7'd1;
                end
            cu_pkg::ST_DIV:
                ;
            cu_pkg::ST_OUT:
                if (!out_v_reg || m_axis_tready)
                begin
                    out_v_next = 1'b1;
                    out_next = bad_reg ? 48'h0400_0000_0000 :
                        {5'd0, 1'b0, pj_reg, pi_reg, clamped[31:0]};
                end
            default:
                ;
        endcase
        if (st_reg == cu_pkg::ST_CLEAR && lc_reg == 17'd0)
            cnt_next = prog_eff;
    end

    logic signed [SW-1:0] quot_hold_reg;
    always_ff @(posedge clk)
    begin
        if (div_done)
            quot_hold_reg <= quot_w;
    end
    assign quot = quot_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= cu_pkg::ST_IDLE;
            out_v_reg <= 1'b0;
            cnt_reg <= '0;
            lc_reg <= '0;
            rd_chunk_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            out_v_reg <= out_v_next;
            cnt_reg <= cnt_next;
            lc_reg <= lc_next;
            rd_chunk_reg <= rd_chunk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        row_reg <= row_next;
        pi_reg <= pi_next;
        pj_reg <= pj_next;
        bad_reg <= bad_next;
        tot_reg <= tot_next;
        rd_addr_reg <= rd_addr_next;
        out_reg <= out_next;
    end

    // the four parent haplotype effects of this locus
    logic signed [SW-1:0] eff_ext;
    assign eff_ext = SW'($signed(eff_rd_reg));
    always_comb
    begin
        x_reg[0] = all_rd_reg[{pi_reg, 1'b0}] ? eff_ext : '0;
        x_reg[1] = all_rd_reg[{pi_reg, 1'b1}] ? eff_ext : '0;
        x_reg[2] = all_rd_reg[{pj_reg, 1'b0}] ? eff_ext : '0;
        x_reg[3] = all_rd_reg[{pj_reg, 1'b1}] ? eff_ext : '0;
    end

    // row of progeny cells
    genvar g;
    generate
        for (g = 0; g < NP; g++)
        begin : g_cell
            logic lowside;
            assign lowside = (g % 2 == 0) ? !cnt_reg[0] : cnt_reg[0];
            cu_cell u_cell (
                .clk(clk),
                .ctl(ctl),
                .active(7'(g) < prog_eff),
                .code_a(code_rd_reg[(2*g)/32][((2*g)%32)*2 +: 2]),
                .code_b(code_rd_reg[(2*g+1)/32][((2*g+1)%32)*2 +: 2]),
                .x0(x_reg[0]),
                .x1(x_reg[1]),
                .x2(x_reg[2]),
                .x3(x_reg[3]),
                .left_val((g == 0) ? cell_v[0] : cell_v[(g == 0) ? 0 : g-1]),
                .right_val((g == NP-1) ? SW'(0) : cell_v[(g == NP-1) ? g : g+1]),
                .is_low(lowside),
                .pair_en(lowside ? (g != NP-1) : (g != 0)),
                .right_in_range(7'(g+1) < prog_eff),
                .val(cell_v[g])
            );
        end
    endgenerate

    cu_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(tot_reg),
        .divisor({2'd0, best_eff}),
        .done(div_done),
        .quotient(quot_w)
    );

    assign s_axis_tready = (st_reg == cu_pkg::ST_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = out_reg;

    // checks
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != cu_pkg::ST_IDLE |-> !s_axis_tready) else $error("ready while busy");
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[42] |-> m_axis_tdata[41:0] == 42'd0)
        else $error("bad pair payload");
endmodule
`default_nettype wire
